/* rtl/sdes_cbc_cipher_assert.svh */
// Assertion macros for the S-DES CBC block.
`ifndef SDES_CBC_CIPHER_ASSERT_SVH
`define SDES_CBC_CIPHER_ASSERT_SVH

`ifndef SYNTHESIS

// Checked outside reset.
`define SDES_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define SDES_ASSERT_ALL(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SDES_ASSERT(label, clk, rst, prop, msg)
`define SDES_ASSERT_ALL(label, clk, prop, msg)

`endif

`endif

/* rtl/sdes_cbc_pkg.sv */
package sdes_cbc_pkg;

   localparam int CSR_DATA_W = 10;
   localparam int CSR_INDEX_W = 2;

   typedef logic [7:0] block_type;
   typedef logic [9:0] key_type;
   typedef logic [7:0] subkey_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_KEY  = 2'd0,
      CSR_IV   = 2'd1,
      CSR_MODE = 2'd2
   } csr_index_type;

   typedef struct packed {
      subkey_type k1;
      subkey_type k2;
      block_type  iv;
      logic       decrypt;
   } cfg_type;

   localparam int P10_TAB [10] = '{3, 5, 2, 7, 4, 10, 1, 9, 8, 6};
   localparam int P8_TAB [8] = '{6, 3, 7, 4, 8, 5, 10, 9};
   localparam int IP_TAB [8] = '{2, 6, 3, 1, 4, 8, 5, 7};
   localparam int IPINV_TAB [8] = '{4, 1, 3, 5, 7, 2, 8, 6};
   localparam int EP_TAB [8] = '{4, 1, 2, 3, 2, 3, 4, 1};
   localparam int P4_TAB [4] = '{2, 4, 3, 1};

   localparam logic [1:0] SBOX0 [4][4] = '{
      '{2'd1, 2'd0, 2'd3, 2'd2},
      '{2'd3, 2'd2, 2'd1, 2'd0},
      '{2'd0, 2'd2, 2'd1, 2'd3},
      '{2'd3, 2'd1, 2'd3, 2'd2}
   };
   localparam logic [1:0] SBOX1 [4][4] = '{
      '{2'd0, 2'd1, 2'd2, 2'd3},
      '{2'd2, 2'd0, 2'd1, 2'd3},
      '{2'd3, 2'd0, 2'd1, 2'd0},
      '{2'd2, 2'd1, 2'd0, 2'd3}
   };

   // Bit 1 of each table is the MSB.
   function automatic logic [9:0] perm_p10(logic [9:0] v);
      logic [9:0] r;
      for (int i = 0; i < 10; i++) begin
         r[9-i] = v[10-P10_TAB[i]];
      end
      return r;
   endfunction

   function automatic logic [7:0] perm_p8(logic [9:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[7-i] = v[10-P8_TAB[i]];
      end
      return r;
   endfunction

   function automatic logic [7:0] perm_ip(logic [7:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[7-i] = v[8-IP_TAB[i]];
      end
      return r;
   endfunction

   function automatic logic [7:0] perm_ipinv(logic [7:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[7-i] = v[8-IPINV_TAB[i]];
      end
      return r;
   endfunction

   function automatic logic [7:0] expand_ep(logic [3:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[7-i] = v[4-EP_TAB[i]];
      end
      return r;
   endfunction

   function automatic logic [3:0] perm_p4(logic [3:0] v);
      logic [3:0] r;
      for (int i = 0; i < 4; i++) begin
         r[3-i] = v[4-P4_TAB[i]];
      end
      return r;
   endfunction

   function automatic logic [4:0] rotl5_1(logic [4:0] x);
      return {x[3:0], x[4]};
   endfunction

   function automatic logic [4:0] rotl5_3(logic [4:0] x);
      return {x[1:0], x[4:2]};
   endfunction

   function automatic block_type round_f(block_type x, subkey_type k);
      logic [7:0] e;
      logic [1:0] s0;
      logic [1:0] s1;
      logic [3:0] p;
      e = expand_ep(x[3:0]) ^ k;
      s0 = SBOX0[{e[7], e[4]}][e[6:5]];
      s1 = SBOX1[{e[3], e[0]}][e[2:1]];
      p = perm_p4({s0, s1});
      return {x[7:4] ^ p, x[3:0]};
   endfunction

   function automatic block_type run_block(block_type x, subkey_type ka, subkey_type kb);
      block_type t;
      t = perm_ip(x);
      t = round_f(t, ka);
      t = {t[3:0], t[7:4]};
      t = round_f(t, kb);
      return perm_ipinv(t);
   endfunction

endpackage

/* rtl/sdes_cbc_csr.sv */
module sdes_cbc_csr (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        csr_write_en,
   input  logic [sdes_cbc_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [sdes_cbc_pkg::CSR_DATA_W-1:0]         csr_wdata,
   output sdes_cbc_pkg::cfg_type                       cfg
);
   import sdes_cbc_pkg::*;

   key_type    key_p10;
   subkey_type k1_in;
   subkey_type k2_in;
   subkey_type k1_ff;
   subkey_type k2_ff;
   block_type  iv_ff;
   logic       decrypt_ff;

   // subkeys are expanded once when the key is written
   always_comb begin
      key_p10 = perm_p10(csr_wdata[9:0]);
      k1_in = perm_p8({rotl5_1(key_p10[9:5]), rotl5_1(key_p10[4:0])});
      k2_in = perm_p8({rotl5_3(key_p10[9:5]), rotl5_3(key_p10[4:0])});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k1_ff <= '0;
         k2_ff <= '0;
         iv_ff <= '0;
         decrypt_ff <= 1'b0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_KEY: begin
               k1_ff <= k1_in;
               k2_ff <= k2_in;
            end
            CSR_IV: begin
               iv_ff <= csr_wdata[7:0];
            end
            CSR_MODE: begin
               decrypt_ff <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   assign cfg = '{k1: k1_ff, k2: k2_ff, iv: iv_ff, decrypt: decrypt_ff};

endmodule

/* rtl/sdes_cbc_core.sv */
`include "sdes_cbc_cipher_assert.svh"

module sdes_cbc_core (
   input  logic                    clock,
   input  logic                    reset,
   input  sdes_cbc_pkg::cfg_type   cfg,
   input  sdes_cbc_pkg::block_type data,
   input  logic                    first,
   input  logic                    advance,
   output sdes_cbc_pkg::block_type result
);
   import sdes_cbc_pkg::*;

   block_type chain_ff;
   block_type chain_in;
   block_type chain;
   block_type enc_out;
   block_type dec_out;

   always_comb begin
      chain = first ? cfg.iv : chain_ff;
      enc_out = run_block(data ^ chain, cfg.k1, cfg.k2);
      dec_out = run_block(data, cfg.k2, cfg.k1) ^ chain;
      result = cfg.decrypt ? dec_out : enc_out;
      chain_in = cfg.decrypt ? data : enc_out;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= '0;
      end else if (advance) begin
         chain_ff <= chain_in;
      end
   end

   `SDES_ASSERT(a_chain_hold, clock, reset, !advance |=> $stable(chain_ff), "chain moved without a word")
   `SDES_ASSERT(a_chain_dec, clock, reset, advance && cfg.decrypt |=> chain_ff == $past(data), "decrypt chain is not the input word")
   `SDES_ASSERT(a_chain_enc, clock, reset, advance && !cfg.decrypt |=> chain_ff == $past(result), "encrypt chain is not the output word")

endmodule

/* rtl/sdes_cbc_cipher.sv */
// S-DES (10-bit key, 8-bit block) in CBC mode. One result word per request word,
// in order. Throughput is one word per clock while rsp_stall is low. rsp_valid
// rises as a word moves from the input register, through the full two-round
// network and chain XOR in one combinational stage, into the output register. The
// chain register updates when a word moves into the output register, so consecutive
// words chain back to back. req_first_block reloads the chain from the IV for
// that word; after reset the chain is zero. Subkeys are expanded when the key
// register is written. Write configuration only while no words are in flight.
`include "sdes_cbc_cipher_assert.svh"

module sdes_cbc_cipher (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_en,
   input  logic [sdes_cbc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sdes_cbc_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [7:0]                           req_data_in,
   input  logic                                 req_first_block,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [7:0]                           rsp_data_out
);
   import sdes_cbc_pkg::*;

   cfg_type   cfg;
   logic      in_valid_ff;
   logic      in_valid_in;
   block_type in_data_ff;
   logic      in_first_ff;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   block_type rsp_data_ff;
   block_type result;
   logic      out_adv;
   logic      move;
   logic      in_load;

   sdes_cbc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_write_en(csr_write_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cfg         (cfg)
   );

   sdes_cbc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .data   (in_data_ff),
      .first  (in_first_ff),
      .advance(move),
      .result (result)
   );

   always_comb begin
      out_adv = !rsp_valid_ff || !rsp_stall;
      move = in_valid_ff && out_adv;
      in_load = !in_valid_ff || out_adv;
      in_valid_in = in_load ? req_valid : in_valid_ff;
      rsp_valid_in = out_adv ? in_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load && req_valid) begin
         in_data_ff <= req_data_in;
         in_first_ff <= req_first_block;
      end
      if (move) begin
         rsp_data_ff <= result;
      end
   end

   assign req_stall = !in_load;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data_out = rsp_data_ff;

   `SDES_ASSERT_ALL(a_reset_empty, clock, reset |=> !in_valid_ff && !rsp_valid_ff, "pipeline not empty after reset")
   `SDES_ASSERT(a_no_loss, clock, reset, in_valid_ff && !out_adv |=> in_valid_ff, "stalled input word dropped")
   `SDES_ASSERT(a_no_dup, clock, reset, rsp_valid_ff && !rsp_stall && !in_valid_ff |=> !rsp_valid_ff, "result word repeated")

endmodule
